### rtl/lkv_pkg.sv
// shared types and constants for the lru key/value cache
// no dependencies; imported by every module of the block
package lkv_pkg;

  localparam int unsigned SLOTS_DEF = 8;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned IN_DW     = KEY_W + VAL_W;
  localparam int unsigned OUT_DW    = VAL_W + KEY_W + VAL_W;
  localparam int unsigned OUT_UW    = 2;

  // tuser bit positions on the result side
  localparam int unsigned UB_HIT   = 0;
  localparam int unsigned UB_EVICT = 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE
  } state_e;

  typedef struct packed {
    logic load_req;
    logic do_match;
    logic do_update;
  } cmd_t;

endpackage

### rtl/lru_key_value_cache.sv
// top level of the fully associative lru key/value cache
// depends on lkv_pkg, lkv_ctrl and lkv_datapath
//
// usage
// - slave stream carries one request per transfer: tdata holds the key and
//   the new value, tuser the replace flag
// - master stream returns exactly one result per request: hit flag, value now
//   held for the key, and the evicted entry when a miss pushed one out
// - each request passes three steps: capture, parallel compare of all slots
//   with highest-match select, then the recency shift and result load; the
//   three-step sequencer has one state per step
// - so a new request is taken only once the sequencer is back in idle after
//   the shift step; the result is loaded into its register in the shift step
// - the result register parts the two sides: a new request is taken while an
//   earlier result still waits; if the receiver stalls, the next request
//   holds in the shift step until the result register frees up
// - reset clears all slot valid bits, the sequencer and the result valid;
//   no clearing pass is needed
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,  // req_key, new_value
  input  logic              s_axis_tuser,  // replace_value
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,  // held_value, evict_key, evict_value
  output logic [OUT_UW-1:0] m_axis_tuser   // hit, evict_valid
);

  cmd_t cmd;

  // sequencer: one request in flight, result valid flag
  lkv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // slots in recency order, slot 0 least recent
  lkv_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_data_i (s_axis_tdata),
    .req_repl_i (s_axis_tuser),
    .res_data_o (m_axis_tdata),
    .res_user_o (m_axis_tuser)
  );

  // one request at a time: a transfer closes the input until the item is done
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[UB_HIT] && m_axis_tuser[UB_EVICT]))
    else $error("eviction flagged on a hit");

  // a fresh result is preceded by its request transfer
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3))
    else $error("result without matching request");

endmodule

### rtl/lkv_datapath.sv
// slot array, parallel key compare, recency shift and result register
// depends on lkv_pkg; driven by lkv_ctrl through cmd_t
module lkv_datapath import lkv_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [IN_DW-1:0]  req_data_i,
  input  logic              req_repl_i,
  output logic [OUT_DW-1:0] res_data_o,
  output logic [OUT_UW-1:0] res_user_o
);

  logic [KEY_W-1:0] key_q [SLOTS];
  logic [VAL_W-1:0] val_q [SLOTS];
  logic [SLOTS-1:0] valid_q;

  logic [KEY_W-1:0] req_key_q;
  logic [VAL_W-1:0] req_val_q;
  logic             req_repl_q;

  logic [SLOTS-1:0] match_w;
  logic [SLOTS-1:0] above_w;
  logic [SLOTS-1:0] sel_d, sel_q;
  logic [SLOTS-1:0] shm_d, shm_q;
  logic             hit_d, hit_q;

  logic [VAL_W-1:0] found_val;
  logic [VAL_W-1:0] held_val;
  logic [OUT_DW-1:0] res_data_q;
  logic [OUT_UW-1:0] res_user_q;

  // compare stage: highest matching slot wins, slots from there up shift down; on a miss all shift
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_w[i] = valid_q[i] && (key_q[i] == req_key_q);
    end
    for (int i = 0; i < SLOTS; i++) begin
      above_w[i] = |(match_w >> (i + 1));
    end
    hit_d = |match_w;
    sel_d = match_w & ~above_w;
    shm_d = hit_d ? ~above_w : {SLOTS{1'b1}};
  end

  always_comb begin
    found_val = '0;
    for (int i = 0; i < SLOTS; i++) begin
      found_val = found_val | (val_q[i] & {VAL_W{sel_q[i]}});
    end
    held_val = (hit_q && !req_repl_q) ? found_val : req_val_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_key_q  <= req_data_i[KEY_W-1:0];
      req_val_q  <= req_data_i[IN_DW-1:KEY_W];
      req_repl_q <= req_repl_i;
    end
    if (cmd_i.do_match) begin
      sel_q <= sel_d;
      shm_q <= shm_d;
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.do_update) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        if (shm_q[i]) valid_q[i] <= valid_q[i + 1];
      end
      valid_q[SLOTS-1] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_update) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        if (shm_q[i]) begin
          key_q[i] <= key_q[i + 1];
          val_q[i] <= val_q[i + 1];
        end
      end
      key_q[SLOTS-1] <= req_key_q;
      val_q[SLOTS-1] <= held_val;
      res_user_q[UB_HIT] <= hit_q;
      if (!hit_q && valid_q[0]) begin
        res_user_q[UB_EVICT] <= 1'b1;
        res_data_q <= {val_q[0], key_q[0], held_val};
      end else begin
        res_user_q[UB_EVICT] <= 1'b0;
        res_data_q <= {{(KEY_W + VAL_W){1'b0}}, held_val};
      end
    end
  end

  assign res_data_o = res_data_q;
  assign res_user_o = res_user_q;

endmodule

### rtl/lkv_ctrl.sv
// request sequencer and result-valid flag for the lru key/value cache
// depends on lkv_pkg; issues cmd_t to lkv_datapath
module lkv_ctrl import lkv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  output logic res_valid_o,
  input  logic res_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   res_valid_q, res_valid_d;
  logic   res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_free = !res_valid_q || res_ready_i;

  always_comb begin
    state_d     = state_q;
    res_valid_d = res_valid_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    if (res_valid_q && res_ready_i) res_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd_o.do_match = 1'b1;
        state_d        = S_UPDATE;
      end
      S_UPDATE: begin
        // result register must be free before the slots move
        if (res_free) begin
          cmd_o.do_update = 1'b1;
          res_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_valid_o = res_valid_q;

endmodule
